// File: src/tlm_pkg.sv
// Shared constants and types for the three-wire link master.
`default_nettype none
package tlm_pkg;

  // Width of the command and state words on the link
  localparam int WORD_BITS = 32;
  // Bit counter covers both words read back to back
  localparam int CNT_W     = $clog2(2 * WORD_BITS + 1);
  localparam int IDX_W     = $clog2(WORD_BITS);
  localparam int PHASE_W   = 5;

  // Input transaction kinds
  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // One result transaction
  typedef struct packed {
    logic                 sel_level;
    logic                 sel_drive;
    logic                 clk_level;
    logic                 clk_drive;
    logic                 data_level;
    logic                 data_drive;
    logic                 busy;
    logic                 done;
    logic [WORD_BITS-1:0] command_value;
    logic [WORD_BITS-1:0] state_value;
  } tlm_res_t;

endpackage
`default_nettype wire

// File: src/tlm_seq.sv
// Phase sequencer: link state registers and the line levels after each transaction.
`default_nettype none
module tlm_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          kind,
  input  logic [tlm_pkg::WORD_BITS-1:0] set_bits,
  input  logic [tlm_pkg::WORD_BITS-1:0] clear_bits,
  input  logic                          data_in,
  output tlm_pkg::tlm_res_t             res
);
  import tlm_pkg::*;

  localparam logic [PHASE_W-1:0] PH_IDLE      = 5'd0;
  localparam logic [PHASE_W-1:0] PH_SEL_LOW   = 5'd1;
  localparam logic [PHASE_W-1:0] PH_CLK_LOW   = 5'd2;
  localparam logic [PHASE_W-1:0] PH_SEL_HIGH  = 5'd3;
  localparam logic [PHASE_W-1:0] PH_LATCH     = 5'd4;
  localparam logic [PHASE_W-1:0] PH_READY     = 5'd5;
  localparam logic [PHASE_W-1:0] PH_RD_HI     = 5'd6;
  localparam logic [PHASE_W-1:0] PH_RD_LO     = 5'd7;
  localparam logic [PHASE_W-1:0] PH_RD_SAMPLE = 5'd8;
  localparam logic [PHASE_W-1:0] PH_ABORT     = 5'd9;
  localparam logic [PHASE_W-1:0] PH_REL_HI    = 5'd10;
  localparam logic [PHASE_W-1:0] PH_REL_DRIVE = 5'd11;
  localparam logic [PHASE_W-1:0] PH_WR_LO     = 5'd12;
  localparam logic [PHASE_W-1:0] PH_WR_DATA   = 5'd13;
  localparam logic [PHASE_W-1:0] PH_WR_HI     = 5'd14;
  localparam logic [PHASE_W-1:0] PH_MR_LO     = 5'd15;
  localparam logic [PHASE_W-1:0] PH_MR_IN     = 5'd16;
  localparam logic [PHASE_W-1:0] PH_FIN_HI    = 5'd17;
  localparam logic [PHASE_W-1:0] PH_FIN_LO    = 5'd18;
  localparam logic [PHASE_W-1:0] PH_STOP      = 5'd19;

  localparam logic [CNT_W-1:0] CNT_WORD = CNT_W'(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);
  localparam logic [CNT_W-1:0] CNT_BOTH = CNT_W'(2 * WORD_BITS);

  logic [PHASE_W-1:0]   phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] cmd_r, cmd_nxt;
  logic [WORD_BITS-1:0] stat_r, stat_nxt;
  logic [WORD_BITS-1:0] set_r, set_nxt;
  logic [WORD_BITS-1:0] clr_r, clr_nxt;
  logic                 done;

  // Advance the phase on a tick, start a transfer on a request while idle
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    stat_nxt  = stat_r;
    set_nxt   = set_r;
    clr_nxt   = clr_r;
    done      = 1'b0;
    if (accept) begin
      if (kind == KIND_REQ) begin
        if (phase_r == PH_IDLE) begin
          set_nxt   = set_bits;
          clr_nxt   = clear_bits;
          cnt_nxt   = '0;
          phase_nxt = PH_SEL_LOW;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE:      phase_nxt = PH_IDLE;
          PH_SEL_LOW:   phase_nxt = PH_CLK_LOW;
          PH_CLK_LOW:   phase_nxt = PH_SEL_HIGH;
          PH_SEL_HIGH:  phase_nxt = PH_LATCH;
          PH_LATCH:     phase_nxt = PH_READY;
          PH_READY: begin
            phase_nxt = PH_RD_HI;
            cnt_nxt   = '0;
          end
          PH_RD_HI:     phase_nxt = PH_RD_LO;
          PH_RD_LO: begin
            // Shift the sampled bit in at the top: words arrive LSB first
            if (cnt_r < CNT_WORD) begin
              cmd_nxt = {data_in, cmd_r[WORD_BITS-1:1]};
            end else begin
              stat_nxt = {data_in, stat_r[WORD_BITS-1:1]};
            end
            cnt_nxt   = cnt_r + CNT_W'(1);
            phase_nxt = PH_RD_SAMPLE;
          end
          PH_RD_SAMPLE: begin
            if (cnt_r < CNT_BOTH) begin
              phase_nxt = PH_RD_HI;
            end else if (set_r == '0 && clr_r == '0) begin
              phase_nxt = PH_ABORT;
            end else begin
              phase_nxt = PH_REL_HI;
            end
          end
          PH_ABORT: begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_REL_HI:    phase_nxt = PH_REL_DRIVE;
          PH_REL_DRIVE: begin
            phase_nxt = PH_WR_LO;
            cnt_nxt   = '0;
          end
          PH_WR_LO:     phase_nxt = PH_WR_DATA;
          PH_WR_DATA:   phase_nxt = PH_WR_HI;
          PH_WR_HI: begin
            if (cnt_r != CNT_LAST) begin
              cnt_nxt   = cnt_r + CNT_W'(1);
              phase_nxt = PH_WR_LO;
            end else begin
              phase_nxt = PH_MR_LO;
            end
          end
          PH_MR_LO:     phase_nxt = PH_MR_IN;
          PH_MR_IN:     phase_nxt = PH_FIN_HI;
          PH_FIN_HI:    phase_nxt = PH_FIN_LO;
          PH_FIN_LO:    phase_nxt = PH_STOP;
          default: begin
            // Stop phase returns to idle
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
        endcase
      end
    end
  end

  // Hold the link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      cmd_r   <= '0;
      stat_r  <= '0;
      set_r   <= '0;
      clr_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      cmd_r   <= cmd_nxt;
      stat_r  <= stat_nxt;
      set_r   <= set_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Write-back word and the bit on the data line
  logic [WORD_BITS-1:0] wr_word;
  logic [CNT_W-1:0]     cnt_m1;
  logic                 bit_cur;
  logic                 bit_prev;

  always_comb begin
    wr_word  = (cmd_nxt | set_nxt) & ~clr_nxt;
    cnt_m1   = cnt_nxt - CNT_W'(1);
    bit_cur  = (cnt_nxt < CNT_WORD) ? wr_word[cnt_nxt[IDX_W-1:0]] : 1'b0;
    bit_prev = (cnt_nxt != '0 && cnt_m1 < CNT_WORD) ? wr_word[cnt_m1[IDX_W-1:0]] : 1'b0;
  end

  // Drive levels for the phase after this transaction
  always_comb begin
    res               = '0;
    res.sel_drive     = 1'b1;
    res.clk_drive     = 1'b1;
    res.busy          = (phase_nxt != PH_IDLE);
    res.done          = done;
    res.command_value = cmd_nxt;
    res.state_value   = stat_nxt;
    unique case (phase_nxt)
      PH_IDLE: begin
        res.sel_drive = 1'b0;
        res.clk_drive = 1'b0;
      end
      PH_SEL_LOW:   res.clk_drive = 1'b0;
      PH_CLK_LOW, PH_ABORT: res.sel_level = 1'b0;
      PH_SEL_HIGH, PH_READY, PH_RD_LO, PH_RD_SAMPLE, PH_MR_IN, PH_FIN_LO:
        res.sel_level = 1'b1;
      PH_LATCH, PH_RD_HI, PH_REL_HI, PH_FIN_HI: begin
        res.sel_level = 1'b1;
        res.clk_level = 1'b1;
      end
      PH_REL_DRIVE: begin
        res.sel_level  = 1'b1;
        res.clk_level  = 1'b1;
        res.data_drive = 1'b1;
      end
      PH_WR_LO: begin
        res.sel_level  = 1'b1;
        res.data_drive = 1'b1;
        res.data_level = bit_prev;
      end
      PH_WR_DATA, PH_MR_LO: begin
        res.sel_level  = 1'b1;
        res.data_drive = 1'b1;
        res.data_level = bit_cur;
      end
      PH_WR_HI: begin
        res.sel_level  = 1'b1;
        res.clk_level  = 1'b1;
        res.data_drive = 1'b1;
        res.data_level = bit_cur;
      end
      default:      res.sel_level = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/three_wire_register_link_master_core.sv
// Top level of the three-wire link master: phase sequencer and result buffer.
//
// Usage: the input channel carries one transaction per request or bus tick.
// A request (in_kind low) latches the set and clear masks and starts a
// transfer if the master is idle; otherwise it is ignored. Each tick (in_kind
// high) moves the bus one phase: select low, latch pulse, 64 read pulses that
// fill the command and state words LSB first, then either abort or release,
// a 32-pulse write-back of (command | set) & ~clear, finish and stop.
// Every input transaction yields exactly one result transaction with the line
// levels and drive enables after it, busy, a done pulse and both words.
// The result is registered into the output register, or into the skid register
// while the output one is still full. One transaction per clock while in_ready is
// high; the phase logic is combinational between state and result registers.
// A two-entry result buffer (output register plus skid register) keeps input
// accepted while one result waits; in_ready falls only when both are full.
// Reset (rst_n low, synchronous) returns to idle with all lines released,
// zero words and masks, and empties the result buffer.
`default_nettype none
module three_wire_register_link_master_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [tlm_pkg::WORD_BITS-1:0] in_set_bits,
  input  logic [tlm_pkg::WORD_BITS-1:0] in_clear_bits,
  input  logic                          in_data_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_sel_level,
  output logic                          out_sel_drive,
  output logic                          out_clk_level,
  output logic                          out_clk_drive,
  output logic                          out_data_level,
  output logic                          out_data_drive,
  output logic                          out_busy_res,
  output logic                          out_done_res,
  output logic [tlm_pkg::WORD_BITS-1:0] out_command_value,
  output logic [tlm_pkg::WORD_BITS-1:0] out_state_value
);
  import tlm_pkg::*;

  logic     in_fire;
  logic     out_fire;
  tlm_res_t seq_res;
  tlm_res_t out_res_r;
  tlm_res_t skid_res_r;
  logic     out_valid_r;
  logic     skid_valid_r;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  tlm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_fire),
    .kind       (in_kind),
    .set_bits   (in_set_bits),
    .clear_bits (in_clear_bits),
    .data_in    (in_data_in),
    .res        (seq_res)
  );

  // Result buffer: refill from skid first, else take the new transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_fire) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire;
        end
      end else if (in_fire) begin
        if (!out_valid_r) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_fire && skid_valid_r) begin
      out_res_r <= skid_res_r;
    end else if (in_fire && (out_fire || !out_valid_r)) begin
      out_res_r <= seq_res;
    end
    if (in_fire && out_valid_r && !out_fire) begin
      skid_res_r <= seq_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sel_level     = out_res_r.sel_level;
  assign out_sel_drive     = out_res_r.sel_drive;
  assign out_clk_level     = out_res_r.clk_level;
  assign out_clk_drive     = out_res_r.clk_drive;
  assign out_data_level    = out_res_r.data_level;
  assign out_data_drive    = out_res_r.data_drive;
  assign out_busy_res      = out_res_r.busy;
  assign out_done_res      = out_res_r.done;
  assign out_command_value = out_res_r.command_value;
  assign out_state_value   = out_res_r.state_value;

`ifndef SYNTHESIS
  // Skid holds a result only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // Skid result moves to the output unchanged when the output drains
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && skid_valid_r |=> out_valid_r && out_res_r == $past(skid_res_r))
    else $error("skid result lost or reordered");

  // A done pulse always leaves the master idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.done |-> !out_res_r.busy)
    else $error("done reported while still busy");

  // Released lines read as low
  a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.sel_drive || !out_res_r.sel_level) &&
                    (out_res_r.clk_drive || !out_res_r.clk_level) &&
                    (out_res_r.data_drive || !out_res_r.data_level))
    else $error("level shown on a released line");
`endif

endmodule
`default_nettype wire
